// ===== rtl/assert_macros.svh =====
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a named clock and reset.
`define ASSERT_AT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Concurrent check on the usual clk / rst pair.
`define ASSERT_CLK(label, prop, msg) `ASSERT_AT(label, clk, rst, prop, msg)

`endif

// ===== rtl/rlespr_pkg.sv =====
// Types, constants and result helpers of the RLE sprite row decoder.
package rlespr_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Row counter saturates here; any cap above the largest height works.
  localparam int ROW_W = 12;
  localparam logic [ROW_W-1:0] ROW_CAP = '1;

  localparam int FIFO_DEPTH = 4;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_RLE_MODE = 3'd2;
  localparam logic [2:0] REG_MIRROR_X = 3'd3;
  localparam logic [2:0] REG_MIRROR_Y = 3'd4;

  localparam logic [1:0] PH_HDR   = 2'd0;
  localparam logic [1:0] PH_CHUNK = 2'd1;
  localparam logic [1:0] PH_LIT   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  dest_row;
    logic [9:0]  dest_col;
    logic [10:0] run_length;
    logic [10:0] run_rows;
    logic [7:0]  pixel_value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } cand_t;

  function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] row,
                                               input logic [14:0] n);
    logic [15:0] sum;
    sum = 16'(row) + 16'(n);
    return (sum > 16'(ROW_CAP)) ? ROW_CAP : sum[ROW_W-1:0];
  endfunction

  function automatic cand_t done_cand();
    cand_t c;
    c = '0;
    c.valid = 1'b1;
    c.res.kind = KIND_DONE;
    c.res.run_rows = 11'd1;
    return c;
  endfunction

  function automatic cand_t calc_pixel(input logic [ROW_W-1:0] row,
                                       input logic signed [17:0] col,
                                       input logic [7:0] val,
                                       input logic [10:0] w, input logic [10:0] h,
                                       input logic mx, input logic my);
    cand_t c;
    logic [10:0] cu, ru;
    cu = col[10:0];
    ru = row[10:0];
    c = '0;
    c.valid = (row < ROW_W'(h)) && (col >= 0) && (col < $signed({7'b0, w}));
    c.res.kind = KIND_PIXEL;
    c.res.dest_col = mx ? 10'(w - 11'd1 - cu) : cu[9:0];
    c.res.dest_row = my ? 10'(h - 11'd1 - ru) : ru[9:0];
    c.res.run_length = 11'd1;
    c.res.run_rows = 11'd1;
    c.res.pixel_value = val;
    return c;
  endfunction

  // Rows [r0, r0+nr), columns [a, b), clipped to the image, then mirrored.
  function automatic cand_t calc_fill(input logic [ROW_W-1:0] r0, input logic [14:0] nr,
                                      input logic signed [17:0] a,
                                      input logic signed [17:0] b,
                                      input logic [10:0] w, input logic [10:0] h,
                                      input logic mx, input logic my);
    cand_t c;
    logic signed [17:0] ws, ac, bc;
    logic [15:0] r1, r1c;
    logic [10:0] ca, cb, rb, re;
    ws  = $signed({7'b0, w});
    ac  = (a < 0) ? 18'sd0 : a;
    bc  = (b > ws) ? ws : b;
    r1  = 16'(r0) + 16'(nr);
    r1c = (r1 > 16'(h)) ? 16'(h) : r1;
    ca  = ac[10:0];
    cb  = bc[10:0];
    rb  = r0[10:0];
    re  = r1c[10:0];
    c = '0;
    c.valid = (ac < bc) && (16'(r0) < r1c);
    c.res.kind = KIND_FILL;
    c.res.dest_col = mx ? 10'(w - cb) : ca[9:0];
    c.res.run_length = cb - ca;
    c.res.dest_row = my ? 10'(h - re) : rb[9:0];
    c.res.run_rows = re - rb;
    return c;
  endfunction

endpackage

// ===== rtl/rle_sprite_row_decoder.sv =====
// Top level of the RLE sprite row decoder: config port, byte decoder, result queue.
//
// Usage:
//   Slave stream (s_*) carries one sprite byte per transaction in s_tdata,
//   with s_tuser[0] set on the first byte of an image to restart decoding.
//   Master stream (m_*) carries result transactions: m_tuser is the kind
//   (pixel, zero-fill rectangle, image finished), m_tdata the row, column,
//   run length, row count and pixel value, m_tlast marks the final result
//   caused by one input byte. A byte causes zero, one or two results.
//   The APB port sets width, height, RLE mode and mirroring between images.
// Timing:
//   Each byte is decoded in the cycle it is taken; its results are written to the
//   result queue and reach the master side from its head. The four-entry queue
//   sets the rate: s_tready is high while two entries are free, so while m_tready
//   is high, bytes that cause at most one result flow at one per cycle, and a byte
//   that causes two takes two transfers on the output side.
// Reset: rst clears the decoder and the queue; registers go to 1x1, raw, no mirroring.
// Stall: a low m_tready holds the head result; with fewer than two entries free,
//   s_tready drops until the receiver drains the queue.
`include "assert_macros.svh"

module rle_sprite_row_decoder
  import rlespr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] first_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [9:0] dest_row, [19:10] dest_col, [30:20] run_length,
                                 // [41:31] run_rows, [49:42] pixel_value, [55:50] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration registers
  logic [10:0] image_width, image_height;
  logic        rle_mode, mirror_x, mirror_y;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1;
      image_height <= 11'd1;
      rle_mode     <= 1'b0;
      mirror_x     <= 1'b0;
      mirror_y     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:    image_width  <= pwdata[10:0];
        REG_HEIGHT:   image_height <= pwdata[10:0];
        REG_RLE_MODE: rle_mode     <= pwdata[0];
        REG_MIRROR_X: mirror_x     <= pwdata[0];
        REG_MIRROR_Y: mirror_y     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:    prdata = {21'b0, image_width};
      REG_HEIGHT:   prdata = {21'b0, image_height};
      REG_RLE_MODE: prdata = {31'b0, rle_mode};
      REG_MIRROR_X: prdata = {31'b0, mirror_x};
      REG_MIRROR_Y: prdata = {31'b0, mirror_y};
      default:      prdata = '0;
    endcase
  end

  logic [10:0] w_eff, h_eff;
  assign w_eff = ({2'b0, image_width} > MaxW) ? MaxW[10:0] : image_width;
  assign h_eff = ({2'b0, image_height} > MaxH) ? MaxH[10:0] : image_height;

  // Decoder state
  logic [1:0]        phase, phase_next;
  logic [1:0]        byte_slot, byte_slot_next;
  logic [23:0]       field_shift, field_shift_next;
  logic [14:0]       rows_left, rows_left_next;
  logic [14:0]       chunks_per_row, chunks_per_row_next;
  logic [14:0]       chunks_left, chunks_left_next;
  logic signed [16:0] skip_col, skip_col_next;
  logic [14:0]       copy_left, copy_left_next;
  logic signed [16:0] filled_to, filled_to_next;
  logic [ROW_W-1:0]  row_index, row_index_next;
  logic [10:0]       col_index, col_index_next;
  logic              image_done, image_done_next;

  // State as seen by this byte (restart applied on first_byte)
  logic              first;
  logic [1:0]        c_phase, c_slot;
  logic [23:0]       c_shift;
  logic [14:0]       c_rows, c_cpr, c_chunks, c_copy;
  logic signed [16:0] c_skip, c_filled;
  logic [ROW_W-1:0]  c_row;
  logic [10:0]       c_col;
  logic              c_done;

  assign first    = s_tuser[0];
  assign c_phase  = first ? PH_HDR : phase;
  assign c_slot   = first ? 2'd0 : byte_slot;
  assign c_shift  = first ? '0 : field_shift;
  assign c_rows   = first ? '0 : rows_left;
  assign c_cpr    = first ? '0 : chunks_per_row;
  assign c_chunks = first ? '0 : chunks_left;
  assign c_skip   = first ? '0 : skip_col;
  assign c_copy   = first ? '0 : copy_left;
  assign c_filled = first ? '0 : filled_to;
  assign c_row    = first ? '0 : row_index;
  assign c_col    = first ? '0 : col_index;
  assign c_done   = first ? 1'b0 : image_done;

  logic signed [15:0] lo, hi;
  logic [11:0]        pitch, col_inc;
  logic [ROW_W-1:0]   row_inc;
  logic               end_chunk;
  logic signed [16:0] tail_from;
  cand_t              cand0, cand1;

  assign lo      = c_shift[15:0];
  assign hi      = {s_tdata, c_shift[23:16]};
  assign pitch   = (12'(w_eff) + 12'd3) & ~12'd3;
  assign col_inc = 12'(c_col) + 12'd1;
  assign row_inc = sat_row(c_row, 15'd1);

  always_comb begin
    phase_next          = c_phase;
    byte_slot_next      = c_slot;
    field_shift_next    = c_shift;
    rows_left_next      = c_rows;
    chunks_per_row_next = c_cpr;
    chunks_left_next    = c_chunks;
    skip_col_next       = c_skip;
    copy_left_next      = c_copy;
    filled_to_next      = c_filled;
    row_index_next      = c_row;
    col_index_next      = c_col;
    image_done_next     = c_done;
    end_chunk           = 1'b0;
    tail_from           = c_filled;
    cand0               = '0;
    cand1               = '0;
    if (!c_done) begin
      if (rle_mode) begin
        if (c_phase == PH_LIT) begin
          cand0 = calc_pixel(c_row, 18'(c_skip), s_tdata, w_eff, h_eff, mirror_x, mirror_y);
          skip_col_next  = c_skip + 17'sd1;
          copy_left_next = c_copy - 15'd1;
          end_chunk      = (c_copy == 15'd1);
        end else if (c_slot != 2'd3) begin
          case (c_slot)
            2'd0:    field_shift_next[7:0]   = s_tdata;
            2'd1:    field_shift_next[15:8]  = s_tdata;
            default: field_shift_next[23:16] = s_tdata;
          endcase
          byte_slot_next = c_slot + 2'd1;
        end else begin
          byte_slot_next   = 2'd0;
          field_shift_next = '0;
          if (c_phase == PH_HDR) begin
            if (lo <= 0) begin
              cand0 = done_cand();
              image_done_next = 1'b1;
            end else if (hi <= 0) begin
              // whole group blank: one rectangle over all its rows
              cand0 = calc_fill(c_row, lo[14:0], 18'sd0, $signed({7'b0, w_eff}),
                                w_eff, h_eff, mirror_x, mirror_y);
              row_index_next = sat_row(c_row, lo[14:0]);
            end else begin
              rows_left_next      = lo[14:0];
              chunks_per_row_next = hi[14:0];
              chunks_left_next    = hi[14:0];
              filled_to_next      = '0;
              phase_next          = PH_CHUNK;
            end
          end else begin
            cand0 = calc_fill(c_row, 15'd1, 18'(c_filled), 18'(lo),
                              w_eff, h_eff, mirror_x, mirror_y);
            filled_to_next = 17'(lo) + 17'(hi);
            skip_col_next  = 17'(lo);
            copy_left_next = (hi > 0) ? hi[14:0] : '0;
            if (hi > 0) begin
              phase_next = PH_LIT;
            end else begin
              end_chunk = 1'b1;
              tail_from = 17'(lo) + 17'(hi);
            end
          end
        end
        if (end_chunk) begin
          chunks_left_next = c_chunks - 15'd1;
          if (c_chunks > 15'd1) begin
            phase_next = PH_CHUNK;
          end else begin
            // row tail after the last chunk
            cand1 = calc_fill(c_row, 15'd1, 18'(tail_from), $signed({7'b0, w_eff}),
                              w_eff, h_eff, mirror_x, mirror_y);
            row_index_next = row_inc;
            rows_left_next = c_rows - 15'd1;
            if (c_rows <= 15'd1) begin
              phase_next = PH_HDR;
            end else begin
              chunks_left_next = c_cpr;
              filled_to_next   = '0;
              phase_next       = PH_CHUNK;
            end
          end
        end
      end else begin
        if (w_eff == '0 || h_eff == '0 || c_row >= ROW_W'(h_eff)) begin
          cand0 = done_cand();
          image_done_next = 1'b1;
        end else begin
          if (c_col < w_eff) begin
            cand0 = calc_pixel(c_row, 18'(c_col), s_tdata, w_eff, h_eff, mirror_x, mirror_y);
          end
          if (col_inc >= pitch) begin
            col_index_next = '0;
            row_index_next = row_inc;
            if (row_inc >= ROW_W'(h_eff)) begin
              cand1 = done_cand();
              image_done_next = 1'b1;
            end
          end else begin
            col_index_next = col_inc[10:0];
          end
        end
      end
    end
  end

  logic s_fire;
  assign s_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR;
      byte_slot      <= '0;
      field_shift    <= '0;
      rows_left      <= '0;
      chunks_per_row <= '0;
      chunks_left    <= '0;
      skip_col       <= '0;
      copy_left      <= '0;
      filled_to      <= '0;
      row_index      <= '0;
      col_index      <= '0;
      image_done     <= 1'b0;
    end else if (s_fire) begin
      phase          <= phase_next;
      byte_slot      <= byte_slot_next;
      field_shift    <= field_shift_next;
      rows_left      <= rows_left_next;
      chunks_per_row <= chunks_per_row_next;
      chunks_left    <= chunks_left_next;
      skip_col       <= skip_col_next;
      copy_left      <= copy_left_next;
      filled_to      <= filled_to_next;
      row_index      <= row_index_next;
      col_index      <= col_index_next;
      image_done     <= image_done_next;
    end
  end

  // Result queue
  res_t             fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic [1:0]       push_n;
  logic             pop;
  res_t             ent0, ent1;

  always_comb begin
    ent0 = cand0.valid ? cand0.res : cand1.res;
    ent0.last = !(cand0.valid && cand1.valid);
    ent1 = cand1.res;
    ent1.last = 1'b1;
  end

  assign push_n   = s_fire ? (2'(cand0.valid) + 2'(cand1.valid)) : 2'd0;
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= ent0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + PTR_W'(1)] <= ent1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  res_t head;
  assign head    = fifo_mem[rd_ptr];
  assign m_tdata = {6'b0, head.pixel_value, head.run_rows, head.run_length,
                    head.dest_col, head.dest_row};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  `ASSERT_CLK(a_fifo_bound, count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_CLK(a_fifo_count, !$past(rst) |-> count == $past(count) + CNT_W'($past(push_n)) - CNT_W'($past(pop)), "queue count out of step")
  `ASSERT_CLK(a_done_last, (m_tvalid && m_tuser == KIND_DONE) |-> m_tlast, "finish result not last")
  `ASSERT_CLK(a_quiet_after_done, (s_fire && image_done && !s_tuser[0]) |-> push_n == 2'd0, "result after image finished")
  `ASSERT_CLK(a_lit_copy, (phase == PH_LIT) |-> copy_left != '0, "literal phase with no bytes left")

endmodule
